// ===== src/assert_macros.svh =====
// Assertion macros used by the tokenizer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_PROP(label, !(cond), msg)

`endif

// ===== src/sqlk_pkg.sv =====
// Shared types, token codes and keyword tables of the SQL tokenizer.
package sqlk_pkg;

  localparam int KW_COUNT = 8;

  // Token kinds beyond the keyword indexes 0..7
  localparam logic [3:0] KIND_IDENT  = 4'd8;
  localparam logic [3:0] KIND_NUMBER = 4'd9;
  localparam logic [3:0] KIND_STRING = 4'd10;
  localparam logic [3:0] KIND_SYMBOL = 4'd11;
  localparam logic [3:0] KIND_END    = 4'd12;

  // End status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_QUOTE = 2'd1;
  localparam logic [1:0] ST_BAD_CHAR = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  // Keyword spellings, first letter in the top byte, short words padded with zeros
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'("INSERT"), 48'("UPDATE"), 48'("DELETE"), 48'("SELECT"),
    {32'("INTO"), 16'h0000}, 48'("VALUES"), {32'("FROM"), 16'h0000},
    {40'("WHERE"), 8'h00}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd6, 3'd6, 3'd6, 3'd6, 3'd4, 3'd6, 3'd4, 3'd5
  };

  // One result token
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start_pos;
    logic [15:0] token_len;
    logic [7:0]  symbol_char;
    logic [1:0]  status;
    logic [7:0]  bad_char;
    logic        last;
  } token_t;

  // Up to two tokens produced by one request, in delivery order
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

endpackage

// ===== src/sqlk_scan.sv =====
// Scanner state and per-byte token logic of the SQL tokenizer.
module sqlk_scan #(
  parameter int POS_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              req_type,
  input  logic [7:0]        char_byte,
  output sqlk_pkg::push_t   push
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_WORD,
    M_NUMBER,
    M_STRING,
    M_ERROR
  } mode_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [POS_BITS-1:0] POS_ONE = {{(POS_BITS-1){1'b0}}, 1'b1};

  mode_t               mode_r, mode_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] start_r, start_nxt;
  logic [7:0]          cand_r, cand_nxt;
  logic [2:0]          wlen_r, wlen_nxt;
  logic [1:0]          err_r, err_nxt;
  logic [7:0]          errb_r, errb_nxt;

  sqlk_pkg::token_t flush_tok, tail_tok;
  logic             flush_v, tail_v, fresh;
  logic [1:0]       end_st;
  logic [15:0]      open_start, open_len, pos16;

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_sym(input logic [7:0] c);
    return (c inside {8'h28, 8'h29, 8'h2C, 8'h3B, 8'h3D, 8'h2A});
  endfunction

  // Narrow the keyword candidates by one more character; returns {cand, wlen}
  function automatic logic [10:0] match_step(input logic [7:0] cand,
                                             input logic [2:0] wlen,
                                             input logic [7:0] c);
    logic [7:0] up;
    logic [7:0] nc;
    logic [7:0] kc;
    logic [2:0] nl;
    up = (c inside {[8'h61:8'h7A]}) ? c - 8'd32 : c;
    nc = cand;
    for (int k = 0; k < sqlk_pkg::KW_COUNT; k++) begin
      kc = 8'(sqlk_pkg::KW_TEXT[k] >> {3'd5 - wlen, 3'b000});
      if (wlen >= sqlk_pkg::KW_LEN[k] || wlen >= 3'd6 || kc != up) begin
        nc[k] = 1'b0;
      end
    end
    nl = (wlen < 3'd7) ? wlen + 3'd1 : wlen;
    return {nc, nl};
  endfunction

  // First surviving keyword of matching length, else identifier
  function automatic logic [3:0] word_kind(input logic [7:0] cand, input logic [2:0] wlen);
    logic [3:0] kind;
    kind = sqlk_pkg::KIND_IDENT;
    for (int k = sqlk_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (cand[k] && sqlk_pkg::KW_LEN[k] == wlen) begin
        kind = 4'(k);
      end
    end
    return kind;
  endfunction

  assign open_start = 16'(start_r);
  assign open_len   = 16'(pos_r - start_r);
  assign pos16      = 16'(pos_r);

  // Next state and the tokens caused by this request
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    cand_nxt  = cand_r;
    wlen_nxt  = wlen_r;
    err_nxt   = err_r;
    errb_nxt  = errb_r;
    flush_v   = 1'b0;
    tail_v    = 1'b0;
    fresh     = 1'b0;
    end_st    = err_r;
    flush_tok = '0;
    tail_tok  = '0;
    flush_tok.start_pos = open_start;
    flush_tok.token_len = open_len;
    flush_tok.kind      = (mode_r == M_WORD) ? word_kind(cand_r, wlen_r)
                                             : sqlk_pkg::KIND_NUMBER;

    if (req_type) begin
      // End of input: flush, report, return to reset state
      flush_v = (mode_r == M_WORD) || (mode_r == M_NUMBER);
      if (mode_r == M_STRING && err_r == sqlk_pkg::ST_OK) begin
        end_st = sqlk_pkg::ST_NO_QUOTE;
      end
      tail_v             = 1'b1;
      tail_tok.kind      = sqlk_pkg::KIND_END;
      tail_tok.start_pos = pos16;
      tail_tok.status    = end_st;
      tail_tok.bad_char  = (end_st == sqlk_pkg::ST_BAD_CHAR) ? errb_r : 8'h00;
      mode_nxt  = M_IDLE;
      pos_nxt   = '0;
      start_nxt = '0;
      cand_nxt  = 8'hFF;
      wlen_nxt  = 3'd0;
      err_nxt   = sqlk_pkg::ST_OK;
      errb_nxt  = 8'h00;
    end else if (mode_r == M_ERROR) begin
      // Drop bytes once an error is latched
    end else if (pos_r == '1) begin
      err_nxt  = sqlk_pkg::ST_TOO_LONG;
      mode_nxt = M_ERROR;
    end else if (mode_r == M_STRING) begin
      if (char_byte == CH_QUOTE) begin
        tail_v             = 1'b1;
        tail_tok.kind      = sqlk_pkg::KIND_STRING;
        tail_tok.start_pos = open_start;
        tail_tok.token_len = open_len;
        mode_nxt           = M_IDLE;
      end
      pos_nxt = pos_r + POS_ONE;
    end else begin
      fresh = 1'b1;
      if (mode_r == M_WORD) begin
        if (is_letter(char_byte) || is_digit(char_byte) || char_byte == CH_UNDER) begin
          {cand_nxt, wlen_nxt} = match_step(cand_r, wlen_r, char_byte);
          pos_nxt = pos_r + POS_ONE;
          fresh   = 1'b0;
        end else begin
          flush_v = 1'b1;
        end
      end else if (mode_r == M_NUMBER) begin
        if (is_digit(char_byte) || char_byte == CH_DOT) begin
          pos_nxt = pos_r + POS_ONE;
          fresh   = 1'b0;
        end else begin
          flush_v = 1'b1;
        end
      end
      // Handle the byte as if the scanner were idle
      if (fresh) begin
        mode_nxt = M_IDLE;
        if (char_byte == CH_SPACE) begin
          // skip
        end else if (is_sym(char_byte)) begin
          tail_v               = 1'b1;
          tail_tok.kind        = sqlk_pkg::KIND_SYMBOL;
          tail_tok.start_pos   = pos16;
          tail_tok.token_len   = 16'd1;
          tail_tok.symbol_char = char_byte;
        end else if (is_letter(char_byte)) begin
          mode_nxt  = M_WORD;
          start_nxt = pos_r;
          {cand_nxt, wlen_nxt} = match_step(8'hFF, 3'd0, char_byte);
        end else if (is_digit(char_byte)) begin
          mode_nxt  = M_NUMBER;
          start_nxt = pos_r;
        end else if (char_byte == CH_QUOTE) begin
          mode_nxt  = M_STRING;
          start_nxt = pos_r;
        end else begin
          err_nxt  = sqlk_pkg::ST_BAD_CHAR;
          errb_nxt = char_byte;
          mode_nxt = M_ERROR;
        end
        if (mode_nxt != M_ERROR) begin
          pos_nxt = pos_r + POS_ONE;
        end
      end
    end

    // Mark the final token of this request
    if (tail_v) begin
      tail_tok.last = 1'b1;
    end else begin
      flush_tok.last = 1'b1;
    end
  end

  assign push.count  = {1'b0, flush_v} + {1'b0, tail_v};
  assign push.first  = flush_v ? flush_tok : tail_tok;
  assign push.second = tail_tok;

  // Hold scanner state; advance when the request is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      cand_r  <= 8'hFF;
      wlen_r  <= 3'd0;
      err_r   <= sqlk_pkg::ST_OK;
      errb_r  <= 8'h00;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      cand_r  <= cand_nxt;
      wlen_r  <= wlen_nxt;
      err_r   <= err_nxt;
      errb_r  <= errb_nxt;
    end
  end

endmodule

// ===== src/sqlk_out_queue.sv =====
// Two-entry result queue whose head register drives the output channel.
module sqlk_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_en,
  input  sqlk_pkg::push_t   push,
  input  logic              out_ready,
  output sqlk_pkg::token_t  head,
  output logic              head_valid,
  output logic [1:0]        free_slots
);

  sqlk_pkg::token_t head_r, head_nxt, tail_r, tail_nxt;
  logic             hv_r, hv_nxt, tv_r, tv_nxt;
  logic             pop;

  assign pop        = hv_r && out_ready;
  assign free_slots = {1'b0, ~hv_r} + {1'b0, ~tv_r} + {1'b0, pop};
  assign head       = head_r;
  assign head_valid = hv_r;

  // Shift out the taken head, then append new tokens
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    hv_nxt   = hv_r;
    tv_nxt   = tv_r;
    if (pop) begin
      head_nxt = tail_r;
      hv_nxt   = tv_r;
      tv_nxt   = 1'b0;
    end
    if (push_en) begin
      case (push.count)
        2'd1: begin
          if (!hv_nxt) begin
            head_nxt = push.first;
            hv_nxt   = 1'b1;
          end else begin
            tail_nxt = push.first;
            tv_nxt   = 1'b1;
          end
        end
        2'd2: begin
          head_nxt = push.first;
          tail_nxt = push.second;
          hv_nxt   = 1'b1;
          tv_nxt   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
      tv_r <= 1'b0;
    end else begin
      hv_r <= hv_nxt;
      tv_r <= tv_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

// ===== src/sql_keyword_tokenizer_unit.sv =====
// Top level of the streaming SQL keyword tokenizer.
// Takes one request per cycle while the queue has room: a character byte or an
// end-of-input marker. Each accepted request is held in the input register, is scanned by
// the per-byte logic and lands in a two-entry result queue whose head drives the output;
// results are registered into the queue when the request leaves the input register. A
// request that ends one token and starts a symbol, or ends the input while a word or
// number is open, yields two results, so the input holds while the queue lacks room for
// them. After the end result the scanner restarts at offset zero.
`include "assert_macros.svh"

module sql_keyword_tokenizer_unit #(
  parameter int POS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic [0:0]  in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] start_pos, [31:16] token_len,
                                  // [39:32] symbol_char, [41:40] status,
                                  // [49:42] bad_char, [55:50] zero
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast   // last_result
);

  logic             in_v_r, in_v_nxt;
  logic             in_req_r;
  logic [7:0]       in_char_r;
  logic             fire;
  logic [1:0]       free_slots;
  sqlk_pkg::push_t  push;
  sqlk_pkg::token_t head;

  // Take the held request once the queue has room for its tokens
  assign fire      = in_v_r && (push.count <= free_slots);
  assign in_tready = !in_v_r || fire;
  assign in_v_nxt  = in_tready ? in_tvalid : in_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
    if (in_tvalid && in_tready) begin
      in_req_r  <= in_tuser[0];
      in_char_r <= in_tdata;
    end
  end

  sqlk_scan #(
    .POS_BITS (POS_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (fire),
    .req_type  (in_req_r),
    .char_byte (in_char_r),
    .push      (push)
  );

  sqlk_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (fire),
    .push       (push),
    .out_ready  (out_tready),
    .head       (head),
    .head_valid (out_tvalid),
    .free_slots (free_slots)
  );

  // Pack the head token onto the output channel
  assign out_tdata = {6'b000000, head.bad_char, head.status, head.symbol_char,
                      head.token_len, head.start_pos};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  `ASSERT_PROP(a_end_is_last, out_tvalid && out_tuser == sqlk_pkg::KIND_END |-> out_tlast, "end token without last flag")
  `ASSERT_PROP(a_end_yields_result, fire && in_req_r |=> out_tvalid, "end request left no result")
  `ASSERT_NEVER(a_token_status_clear, out_tvalid && out_tuser != sqlk_pkg::KIND_END && out_tdata[49:40] != 10'd0, "status on a non-end token")

endmodule
